### design/adb_pkg.sv
// ----------------------------------------------------------------------------
// adb_pkg
// Shared types and constants of the message deframer: header layout, item tag
// passed from the front to the back, status codes and register indexes.
// ----------------------------------------------------------------------------
package adb_pkg;

  // Header layout: six little-endian 32-bit words
  localparam int HEADER_BYTES = 24;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam logic [HDR_IDX_W-1:0] LAST_HDR_IDX = HDR_IDX_W'(HEADER_BYTES - 1);

  // Word numbers inside the header
  localparam logic [2:0] WORD_COMMAND = 3'd0;
  localparam logic [2:0] WORD_ARG0    = 3'd1;
  localparam logic [2:0] WORD_ARG1    = 3'd2;
  localparam logic [2:0] WORD_LENGTH  = 3'd3;
  localparam logic [2:0] WORD_CHECK   = 3'd4;
  localparam logic [2:0] WORD_MAGIC   = 3'd5;

  localparam logic [31:0] CMD_CONNECT        = 32'h4e58_4e43;
  localparam logic [31:0] VERSION_SKIP_CHECK = 32'h0100_0001;

  // Configuration
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 21;
  localparam int PAYLOAD_W  = 21;

  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_NO_AUTH = CFG_IDX_W'(1);

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_LIMIT_RESET = PAYLOAD_W'(4096);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // What the front decided about an item
  typedef enum logic [1:0] {
    END_NONE      = 2'd0,
    END_BAD_MAGIC = 2'd1,
    END_OVERSIZED = 2'd2,
    END_FINISH    = 2'd3
  } end_code_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_CONNECT_OK   = 3'd0,
    ST_BAD_MAGIC    = 3'd1,
    ST_OVERSIZED    = 3'd2,
    ST_BAD_CHECKSUM = 3'd3,
    ST_UNSUPPORTED  = 3'd4,
    ST_AUTH_REFUSED = 3'd5
  } status_t;

  // Classified item carried through the queue
  typedef struct packed {
    logic [7:0]           data;
    logic                 is_hdr;
    logic [HDR_IDX_W-1:0] idx;
    end_code_t            endc;
  } adb_item_t;

endpackage

### design/adb_if.sv
// ----------------------------------------------------------------------------
// adb_if
// Channel interfaces of the deframer: received bytes, status results and
// configuration writes.
// ----------------------------------------------------------------------------
interface adb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface adb_status_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] msg_command;
  logic [31:0] msg_arg0;
  logic [31:0] msg_arg1;
  logic        send_reply;

  modport source (output valid, output status, output msg_command, output msg_arg0,
                  output msg_arg1, output send_reply, input ready);
  modport sink   (input valid, input status, input msg_command, input msg_arg0,
                  input msg_arg1, input send_reply, output ready);
endinterface

interface adb_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [20:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/adb_front.sv
// ----------------------------------------------------------------------------
// adb_front
// Tracks the position in the message stream, checks magic and length as the
// header arrives and tags each byte with where it sits and what it ends.
// ----------------------------------------------------------------------------
module adb_front
  import adb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic [PAYLOAD_W-1:0] payload_limit,
  output logic                 push_valid,
  input  logic                 push_ready,
  output adb_item_t            push_item
);

  logic [HDR_IDX_W-1:0] hdr_cnt;
  logic                 in_payload;
  logic [PAYLOAD_W-1:0] pay_cnt;
  logic [31:0]          command;
  logic [31:0]          length;
  logic                 magic_ok;

  logic                 fire;
  logic [HDR_IDX_W-1:0] hdr_word;
  logic                 magic_match;
  logic [PAYLOAD_W-1:0] pay_cnt_next;
  logic                 hdr_last;
  end_code_t            endc;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign fire       = in_valid && push_ready;

  assign hdr_word     = hdr_cnt >> 2;
  assign magic_match  = (in_byte == ~command[8*hdr_cnt[1:0] +: 8]);
  assign pay_cnt_next = pay_cnt + PAYLOAD_W'(1);
  assign hdr_last     = !in_payload && (hdr_cnt == LAST_HDR_IDX);

  // Classify the current byte
  always_comb begin
    endc = END_NONE;
    if (in_payload) begin
      if (pay_cnt_next == length[PAYLOAD_W-1:0]) begin
        endc = END_FINISH;
      end
    end else if (hdr_last) begin
      if (!(magic_ok && magic_match)) begin
        endc = END_BAD_MAGIC;
      end else if (length > {{(32-PAYLOAD_W){1'b0}}, payload_limit}) begin
        endc = END_OVERSIZED;
      end else if (length == '0) begin
        endc = END_FINISH;
      end
    end
  end

  assign push_item.data   = in_byte;
  assign push_item.is_hdr = !in_payload;
  assign push_item.idx    = hdr_cnt;
  assign push_item.endc   = endc;

  // Advance position and capture the fields the front needs
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_cnt    <= '0;
      in_payload <= 1'b0;
      pay_cnt    <= '0;
      magic_ok   <= 1'b0;
    end else if (fire) begin
      if (in_payload) begin
        if (endc == END_FINISH) begin
          in_payload <= 1'b0;
          pay_cnt    <= '0;
        end else begin
          pay_cnt <= pay_cnt_next;
        end
      end else begin
        if (hdr_word == HDR_IDX_W'(WORD_MAGIC)) begin
          magic_ok <= (hdr_cnt[1:0] == 2'd0) ? magic_match : (magic_ok && magic_match);
        end
        if (hdr_last) begin
          hdr_cnt    <= '0;
          pay_cnt    <= '0;
          in_payload <= (endc == END_NONE);
        end else begin
          hdr_cnt <= hdr_cnt + HDR_IDX_W'(1);
        end
      end
    end
  end

  // Capture command and length bytes
  always_ff @(posedge clk) begin
    if (fire && !in_payload) begin
      if (hdr_word == HDR_IDX_W'(WORD_COMMAND)) begin
        command[8*hdr_cnt[1:0] +: 8] <= in_byte;
      end
      if (hdr_word == HDR_IDX_W'(WORD_LENGTH)) begin
        length[8*hdr_cnt[1:0] +: 8] <= in_byte;
      end
    end
  end

`ifndef SYNTHESIS
  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (rst)
    hdr_cnt <= LAST_HDR_IDX)
    else $error("header count beyond last header byte");
  a_payload_header_clear: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (hdr_cnt == '0))
    else $error("header count not cleared during payload");
`endif

endmodule

### design/adb_queue.sv
// ----------------------------------------------------------------------------
// adb_queue
// Short first-in first-out queue of classified items between the front and
// the back of the deframer.
// ----------------------------------------------------------------------------
module adb_queue
  import adb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  adb_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output adb_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  adb_item_t      entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  logic push_fire;
  logic pop_fire;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CW'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CW'(1);
      end
    end
  end

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");
`endif

endmodule

### design/adb_back.sv
// ----------------------------------------------------------------------------
// adb_back
// Gathers the header words, sums the payload and turns each message end into
// a status result held in the output register.
// ----------------------------------------------------------------------------
module adb_back
  import adb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  adb_item_t pop_item,
  input  logic      allow_no_auth,
  adb_status_if.source tx
);

  logic [31:0] command;
  logic [31:0] arg0;
  logic [31:0] arg1;
  logic [31:0] check;
  logic [31:0] sum;

  logic        out_valid;
  status_t     out_status;
  logic [31:0] out_command;
  logic [31:0] out_arg0;
  logic [31:0] out_arg1;
  logic        out_reply;

  logic                 pop_fire;
  logic [HDR_IDX_W-1:0] hdr_word;
  logic [31:0]          sum_next;
  logic                 skip_check;
  status_t              status_next;

  assign pop_ready = !out_valid || tx.ready;
  assign pop_fire  = pop_valid && pop_ready;
  assign hdr_word  = pop_item.idx >> 2;
  assign sum_next  = pop_item.is_hdr ? sum : sum + {24'd0, pop_item.data};

  assign skip_check = (arg0 >= VERSION_SKIP_CHECK) && (check == '0);

  // Decide the status of a finished or rejected message
  always_comb begin
    unique case (pop_item.endc)
      END_BAD_MAGIC: status_next = ST_BAD_MAGIC;
      END_OVERSIZED: status_next = ST_OVERSIZED;
      default: begin
        if ((check != sum_next) && !skip_check) begin
          status_next = ST_BAD_CHECKSUM;
        end else if (command != CMD_CONNECT) begin
          status_next = ST_UNSUPPORTED;
        end else if (!allow_no_auth) begin
          status_next = ST_AUTH_REFUSED;
        end else begin
          status_next = ST_CONNECT_OK;
        end
      end
    endcase
  end

  // Store header bytes
  always_ff @(posedge clk) begin
    if (pop_fire && pop_item.is_hdr) begin
      if (hdr_word == HDR_IDX_W'(WORD_COMMAND)) begin
        command[8*pop_item.idx[1:0] +: 8] <= pop_item.data;
      end
      if (hdr_word == HDR_IDX_W'(WORD_ARG0)) begin
        arg0[8*pop_item.idx[1:0] +: 8] <= pop_item.data;
      end
      if (hdr_word == HDR_IDX_W'(WORD_ARG1)) begin
        arg1[8*pop_item.idx[1:0] +: 8] <= pop_item.data;
      end
      if (hdr_word == HDR_IDX_W'(WORD_CHECK)) begin
        check[8*pop_item.idx[1:0] +: 8] <= pop_item.data;
      end
    end
  end

  // Accumulate the payload sum, clear it at each message end
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (pop_fire) begin
      sum <= (pop_item.endc != END_NONE) ? '0 : sum_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_fire && (pop_item.endc != END_NONE)) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire && (pop_item.endc != END_NONE)) begin
      out_status  <= status_next;
      out_command <= command;
      out_arg0    <= arg0;
      out_arg1    <= arg1;
      out_reply   <= (status_next == ST_CONNECT_OK);
    end
  end

  assign tx.valid       = out_valid;
  assign tx.status      = out_status;
  assign tx.msg_command = out_command;
  assign tx.msg_arg0    = out_arg0;
  assign tx.msg_arg1    = out_arg1;
  assign tx.send_reply  = out_reply;

`ifndef SYNTHESIS
  a_reply_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_reply == (out_status == ST_CONNECT_OK)))
    else $error("reply flag disagrees with status");
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && (pop_item.endc != END_NONE)) |=> (sum == '0))
    else $error("payload sum not cleared after message end");
`endif

endmodule

### design/adb_message_deframer.sv
// ----------------------------------------------------------------------------
// adb_message_deframer
// Byte-serial deframer for debug-bridge messages with a status per message.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle, sustained, as long as results are
// taken. A front stage tags each byte (header position, payload, magic and
// length verdict) and a two-entry queue hands it to a back stage that keeps
// the header words and the payload sum. A status result is registered in the
// output register once the byte that ends the message has left the queue:
// the last header byte for a rejected header or an empty payload, otherwise
// the last payload byte. Input stalls only when the queue fills behind an
// untaken result. Configuration writes are always taken and must be made
// while no message is in flight. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module adb_message_deframer
  import adb_pkg::*;
#(
  parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  adb_cfg_if.sink      cfg,
  adb_byte_if.sink     rx,
  adb_status_if.source tx
);

  logic [PAYLOAD_W-1:0] payload_limit;
  logic                 allow_no_auth;

  logic      push_valid;
  logic      push_ready;
  adb_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  adb_item_t pop_item;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= PAYLOAD_LIMIT_RESET;
      allow_no_auth <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_PAYLOAD_LIMIT) begin
        payload_limit <= cfg.data[PAYLOAD_W-1:0];
      end
      if (cfg.index == REG_ALLOW_NO_AUTH) begin
        allow_no_auth <= cfg.data[0];
      end
    end
  end

  adb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (rx.valid),
    .in_ready      (rx.ready),
    .in_byte       (rx.rx_byte),
    .payload_limit (payload_limit),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  adb_queue #(
    .DEPTH (QUEUE_ENTRIES)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  adb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .allow_no_auth (allow_no_auth),
    .tx            (tx)
  );

endmodule

### test/adb_message_deframer_test.sv
// ----------------------------------------------------------------------------
// adb_message_deframer_test
// Self-checking bench for the debug-bridge message deframer. Bytes go in on
// the rx channel in random bursts while the status channel stalls on its own
// pattern. A byte-level mirror of the parser predicts each status result,
// which is checked field by field. Directed messages cover every status, the
// header rejections, the checksum skip rule and the payload limits; random
// traffic then runs under several register settings.
// ----------------------------------------------------------------------------
module adb_message_deframer_test;
  import adb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(8'hff);
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 5000;

  typedef enum logic [1:0] {CHK_SUM, CHK_ZERO, CHK_WRONG} check_kind_t;
  typedef enum logic [1:0] {TAKE_ALL, TAKE_COIN, TAKE_PATTERN, TAKE_HOLD} take_mode_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] command;
    logic [31:0] arg0;
    logic [31:0] arg1;
    logic        reply;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  adb_cfg_if    cfg ();
  adb_byte_if   rx ();
  adb_status_if tx ();

  adb_message_deframer uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .rx  (rx),
    .tx  (tx)
  );

  // Mirror of the parser and its registers
  logic [7:0]           rx_hdr [HEADER_BYTES];
  int unsigned          hdr_fill;
  logic [PAYLOAD_W-1:0] body_count;
  logic [31:0]          body_sum;
  logic [PAYLOAD_W-1:0] lim_payload;
  logic                 no_auth_ok;

  verdict_t    verdict_q [$];
  int unsigned verdicts_due = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  // Receiver stall pattern state
  take_mode_t  take_mode = TAKE_ALL;
  int unsigned take_span = 0;
  int unsigned hold_left = 0;
  logic [7:0]  take_pat = 8'hff;
  logic [2:0]  pat_pos = 3'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] hdr_word(input int unsigned w);
    return {rx_hdr[4*w+3], rx_hdr[4*w+2], rx_hdr[4*w+1], rx_hdr[4*w]};
  endfunction

  function automatic void clear_mirror();
    foreach (rx_hdr[i]) rx_hdr[i] = 8'h00;
    hdr_fill = 0;
    body_count = '0;
    body_sum = 32'h0;
  endfunction

  // Queue the status for the current header and start a fresh message
  function automatic void post_verdict(input status_t st);
    verdict_t v;
    v.status = st;
    v.command = hdr_word(WORD_COMMAND);
    v.arg0 = hdr_word(WORD_ARG0);
    v.arg1 = hdr_word(WORD_ARG1);
    v.reply = (st == ST_CONNECT_OK);
    verdict_q.push_back(v);
    verdicts_due++;
    clear_mirror();
  endfunction

  // Judge a message whose payload is complete
  function automatic void close_message();
    logic [31:0] check;
    check = hdr_word(WORD_CHECK);
    if (check != body_sum && !(hdr_word(WORD_ARG0) >= VERSION_SKIP_CHECK && check == 32'h0))
      post_verdict(ST_BAD_CHECKSUM);
    else if (hdr_word(WORD_COMMAND) != CMD_CONNECT)
      post_verdict(ST_UNSUPPORTED);
    else if (!no_auth_ok)
      post_verdict(ST_AUTH_REFUSED);
    else
      post_verdict(ST_CONNECT_OK);
  endfunction

  // Advance the mirror by one accepted byte
  function automatic void deframe_byte(input logic [7:0] value);
    logic [31:0] body_len;
    if (hdr_fill < HEADER_BYTES) begin
      rx_hdr[hdr_fill] = value;
      hdr_fill++;
      if (hdr_fill == HEADER_BYTES) begin
        body_len = hdr_word(WORD_LENGTH);
        if (hdr_word(WORD_MAGIC) != ~hdr_word(WORD_COMMAND))
          post_verdict(ST_BAD_MAGIC);
        else if (body_len > {11'b0, lim_payload})
          post_verdict(ST_OVERSIZED);
        else if (body_len == 32'h0)
          close_message();
      end
    end else begin
      body_sum += {24'h0, value};
      body_count++;
      if ({11'b0, body_count} == hdr_word(WORD_LENGTH))
        close_message();
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  // Send one byte; idle in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        rx.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 32);
    end
    rx.valid = 1'b1;
    rx.rx_byte = value;
    do @(posedge clk); while (!rx.ready);
    deframe_byte(value);
    burst_left--;
    @(negedge clk);
  endtask

  // Send a header and some payload bytes; the check word follows chk
  task automatic send_msg(input logic [31:0] cmd, input logic [31:0] arg0,
                          input logic [31:0] arg1, input logic [31:0] len,
                          input check_kind_t chk, input logic [31:0] magic,
                          input int unsigned body_bytes);
    logic [31:0] words [6];
    logic [7:0]  body [$];
    logic [31:0] sum;
    sum = 32'h0;
    body = {};
    repeat (body_bytes) begin
      body.push_back(8'($urandom));
      sum += {24'h0, body[$]};
    end
    words[WORD_COMMAND] = cmd;
    words[WORD_ARG0]    = arg0;
    words[WORD_ARG1]    = arg1;
    words[WORD_LENGTH]  = len;
    words[WORD_MAGIC]   = magic;
    case (chk)
      CHK_ZERO:  words[WORD_CHECK] = 32'h0;
      CHK_WRONG: words[WORD_CHECK] = sum + $urandom_range(1, 255);
      default:   words[WORD_CHECK] = sum;
    endcase
    for (int i = 0; i < HEADER_BYTES; i++)
      send_byte(words[i/4][8*(i%4) +: 8]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic send_good(input logic [31:0] cmd, input logic [31:0] arg0,
                           input logic [31:0] len, input check_kind_t chk);
    send_msg(cmd, arg0, $urandom, len, chk, ~cmd, len);
  endtask

  // Stop sending, wait for every status, then let the pipeline empty
  task automatic settle();
    int unsigned waited;
    waited = 0;
    rx.valid = 1'b0;
    while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value, input bit more);
    cfg.valid = 1'b1;
    cfg.index = index;
    cfg.data = value;
    do @(posedge clk); while (!cfg.ready);
    if (index == REG_PAYLOAD_LIMIT)
      lim_payload = value[PAYLOAD_W-1:0];
    else if (index == REG_ALLOW_NO_AUTH)
      no_auth_ok = value[0];
    @(negedge clk);
    if (!more) cfg.valid = 1'b0;
  endtask

  // Finish any partial message so the block is idle, then program both registers
  task automatic set_regs(input logic [CFG_DATA_W-1:0] max_len, input logic allow);
    while (hdr_fill != 0) send_byte(8'($urandom));
    settle();
    write_reg(REG_PAYLOAD_LIMIT, max_len, 1'b1);
    write_reg(REG_ALLOW_NO_AUTH, {20'h0, allow}, 1'b0);
  endtask

  // Check every status item against the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && tx.valid && tx.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected status %0d", tx.status));
      end else begin
        want = verdict_q.pop_front();
        if (tx.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", tx.status, want.status));
        if (tx.msg_command !== want.command)
          report_mismatch($sformatf("msg_command %h, predicted %h",
                                    tx.msg_command, want.command));
        if (tx.msg_arg0 !== want.arg0)
          report_mismatch($sformatf("msg_arg0 %h, predicted %h", tx.msg_arg0, want.arg0));
        if (tx.msg_arg1 !== want.arg1)
          report_mismatch($sformatf("msg_arg1 %h, predicted %h", tx.msg_arg1, want.arg1));
        if (tx.send_reply !== want.reply)
          report_mismatch($sformatf("send_reply %b, predicted %b", tx.send_reply, want.reply));
      end
    end
  end

  // Stall the status channel on a changing pattern
  always @(negedge clk) begin
    if (take_span == 0) begin
      take_mode = take_mode_t'($urandom_range(0, 3));
      take_span = $urandom_range(40, 200);
      take_pat = 8'($urandom_range(1, 255));
    end
    take_span--;
    case (take_mode)
      TAKE_ALL: tx.ready = 1'b1;
      TAKE_COIN: tx.ready = ($urandom_range(0, 1) == 1);
      TAKE_PATTERN: begin
        tx.ready = take_pat[pat_pos];
        pat_pos = pat_pos + 3'd1;
      end
      default: begin
        if (hold_left == 0) begin
          tx.ready = ~tx.ready;
          hold_left = tx.ready ? $urandom_range(1, 4) : $urandom_range(5, 20);
        end
        hold_left--;
      end
    endcase
  end

  // Defaults after reset: connect refused, limit of 4096 bytes
  task automatic test_reset_state();
    send_msg(CMD_CONNECT, 32'h0100_0000, 32'h0004_0000, 32'd0, CHK_SUM, ~CMD_CONNECT, 0);
    send_msg(CMD_CONNECT, 32'h0, 32'h0, 32'd4097, CHK_SUM, ~CMD_CONNECT, 0);
  endtask

  // Register writes, an unknown index and the upper data bits
  task automatic test_registers();
    settle();
    write_reg(REG_ALLOW_NO_AUTH, 21'h1, 1'b1);
    write_reg(REG_UNUSED, 21'h0, 1'b1);
    write_reg(REG_PAYLOAD_LIMIT, 21'h1f_ffff, 1'b0);
    send_msg(CMD_CONNECT, 32'h0100_0000, 32'h0010_0000, 32'd5, CHK_SUM, ~CMD_CONNECT, 5);
    send_msg(CMD_CONNECT, 32'h0, 32'h0, 32'h0020_0000, CHK_SUM, ~CMD_CONNECT, 0);
    settle();
    write_reg(REG_UNUSED, 21'h1f_ffff, 1'b1);
    write_reg(REG_ALLOW_NO_AUTH, 21'h1f_fffe, 1'b0);
    send_msg(CMD_CONNECT, 32'hffff_ffff, 32'hffff_ffff, 32'd3, CHK_SUM, ~CMD_CONNECT, 3);
  endtask

  // Magic must be the inverted command
  task automatic test_bad_magic();
    set_regs(21'd4096, 1'b1);
    send_msg(32'h0, 32'h0, 32'h0, 32'h0, CHK_ZERO, 32'h0, 0);
    send_msg(CMD_CONNECT, 32'h0, 32'h0, 32'd8, CHK_SUM, ~CMD_CONNECT ^ 32'h8000_0000, 0);
    send_msg(32'h0, 32'h0, 32'h0, 32'h0, CHK_ZERO, 32'hffff_ffff, 0);
  endtask

  // Length against the limit, at zero and at 2^20
  task automatic test_payload_limit();
    set_regs(21'd0, 1'b1);
    send_good(CMD_CONNECT, 32'h0, 32'd0, CHK_SUM);
    send_msg(CMD_CONNECT, 32'h0, 32'h0, 32'd1, CHK_SUM, ~CMD_CONNECT, 0);
    set_regs(21'd1048576, 1'b1);
    send_msg(CMD_CONNECT, 32'h0, 32'h0, 32'd1048577, CHK_SUM, ~CMD_CONNECT, 0);
    send_good(CMD_CONNECT, 32'h0, 32'd16, CHK_SUM);
  endtask

  // Checksum, its skip rule and the order of the verdicts
  task automatic test_checksum();
    set_regs(21'd4096, 1'b1);
    send_good(CMD_CONNECT, 32'h0, 32'd2, CHK_WRONG);
    send_good(CMD_CONNECT, VERSION_SKIP_CHECK, 32'd2, CHK_ZERO);
    send_good(CMD_CONNECT, VERSION_SKIP_CHECK - 32'd1, 32'd2, CHK_ZERO);
    send_good(CMD_CONNECT, VERSION_SKIP_CHECK, 32'd2, CHK_WRONG);
    send_good(32'h4553_4e59, 32'h0, 32'd2, CHK_SUM);
    set_regs(21'd4096, 1'b0);
    send_good(CMD_CONNECT, 32'h0, 32'd2, CHK_WRONG);
    send_good(CMD_CONNECT, 32'h0, 32'd2, CHK_SUM);
  endtask

  // Mostly well-formed messages with random content, some broken ones and noise
  task automatic random_message();
    logic [31:0] cmd, ver, len, cap, over;
    check_kind_t chk;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    cap = (lim_payload > 16) ? 32'd16 : {11'b0, lim_payload};
    case ($urandom_range(0, 4))
      0, 1, 2: cmd = CMD_CONNECT;
      3:       cmd = $urandom;
      default: cmd = CMD_CONNECT ^ (32'h1 << $urandom_range(0, 31));
    endcase
    case ($urandom_range(0, 4))
      0:       ver = $urandom;
      1:       ver = VERSION_SKIP_CHECK;
      2:       ver = VERSION_SKIP_CHECK - 32'd1;
      3:       ver = 32'hffff_ffff;
      default: ver = 32'h0;
    endcase
    len = $urandom_range(0, cap);
    if ($urandom_range(0, 9) == 0 && lim_payload <= 64)
      len = {11'b0, lim_payload};
    case ($urandom_range(0, 5))
      0:       chk = CHK_ZERO;
      1:       chk = CHK_WRONG;
      default: chk = CHK_SUM;
    endcase
    if ($urandom_range(0, 1) == 0)
      over = {11'b0, lim_payload} + 32'd1 + $urandom_range(0, 3);
    else
      over = $urandom_range({11'b0, lim_payload} + 32'd1, 32'hffff_ffff);
    if (pick < 70)
      send_msg(cmd, ver, $urandom, len, chk, ~cmd, len);
    else if (pick < 78)
      send_msg(cmd, ver, $urandom, len, chk, ~cmd ^ (32'h1 << $urandom_range(0, 31)), 0);
    else if (pick < 86)
      send_msg(cmd, ver, $urandom, over, chk, ~cmd, 0);
    else if (pick < 93)
      repeat ($urandom_range(1, 30)) send_byte(8'($urandom));
    else
      send_msg(cmd, ver, $urandom, len, chk, ~cmd, len / 2);
  endtask

  task automatic random_phase(input logic [CFG_DATA_W-1:0] max_len, input logic allow);
    int unsigned goal;
    set_regs(max_len, allow);
    goal = verdicts_due + 1;
    while (verdicts_due < goal) random_message();
  endtask

  task automatic test_random_traffic();
    random_phase(21'd4096, 1'b1);
    random_phase(21'd0, 1'b1);
    random_phase(21'($urandom_range(1, 64)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    tx.ready = 1'b0;
    lim_payload = PAYLOAD_LIMIT_RESET;
    no_auth_ok = 1'b0;
    clear_mirror();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_registers();
    test_bad_magic();
    test_payload_limit();
    test_checksum();
    test_random_traffic();

    while (hdr_fill != 0) send_byte(8'($urandom));
    settle();
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d predicted status items never came", verdict_q.size()));
    if (mismatches == 0)
      $display("adb_message_deframer_test: PASS");
    else
      $display("adb_message_deframer_test: FAIL");
    $finish;
  end

  // Give up on a hung run
  initial begin
    #5_000_000;
    $display("adb_message_deframer_test: FAIL");
    $finish;
  end

endmodule

### adb_message_deframer.f
design/adb_pkg.sv
design/adb_if.sv
design/adb_front.sv
design/adb_queue.sv
design/adb_back.sv
design/adb_message_deframer.sv
test/adb_message_deframer_test.sv
